/* sv/gpc_pkg.sv */
package gpc_pkg;

   // fixed field widths
   localparam int CMD_W       = 3;
   localparam int PIN_W       = 6;
   localparam int VALUE_W     = 3;
   localparam int FSEL_W      = 3;
   localparam int STATUS_W    = 2;
   localparam int PULL_W      = 2;
   localparam int LATCH_WIDTH = 54;

   // packed stream words, padded to whole bytes
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 64;
   localparam int REQ_USED_W  = CMD_W + PIN_W + VALUE_W + LATCH_WIDTH;
   localparam int RSP_USED_W  = FSEL_W + STATUS_W + LATCH_WIDTH + 1 + PULL_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ_MODE   = 3'd0,
      CMD_WRITE_MODE  = 3'd1,
      CMD_SET_PULL    = 3'd2,
      CMD_READ_LEVEL  = 3'd3,
      CMD_WRITE_LEVEL = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_DISABLED = 2'd1,
      ST_UNIMPL   = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   // request word, first field in the low bits
   typedef struct packed {
      logic [LATCH_WIDTH-1:0] pad_levels;
      logic [VALUE_W-1:0]     value;
      logic [PIN_W-1:0]       pin;
      logic [CMD_W-1:0]       cmd;
   } req_word_type;

   // response word, first field in the low bits
   typedef struct packed {
      logic [PULL_W-1:0]      pull_code;
      logic                   pull_strobe;
      logic [LATCH_WIDTH-1:0] driven_levels;
      status_type             status;
      logic [FSEL_W-1:0]      read_value;
   } rsp_word_type;

   // function select write request
   typedef struct packed {
      logic              en;
      logic [PIN_W-1:0]  addr;
      logic [FSEL_W-1:0] data;
   } sel_wr_type;

endpackage

/* sv/gpc_ram.sv */
module gpc_ram #(
   parameter int WIDTH  = 3,
   parameter int DEPTH  = 54,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/gpc_sel_store.sv */
module gpc_sel_store #(
   parameter int PIN_COUNT = 54
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [gpc_pkg::PIN_W-1:0]  rd_pin,
   input  gpc_pkg::sel_wr_type        wr,
   output logic [gpc_pkg::FSEL_W-1:0] rd_data
);

   import gpc_pkg::*;

   localparam int SEL_AW   = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
   localparam int VLD_SIZE = 2 ** SEL_AW;

   logic [SEL_AW-1:0]   rd_addr;
   logic [SEL_AW-1:0]   wr_addr;
   logic [FSEL_W-1:0]   ram_q;
   logic [VLD_SIZE-1:0] valid_ff;
   logic                vld_q_ff;
   logic                fwd_ff;
   logic [FSEL_W-1:0]   fwd_data_ff;

   assign rd_addr = rd_pin[SEL_AW-1:0];
   assign wr_addr = wr.addr[SEL_AW-1:0];

   gpc_ram #(
      .WIDTH (FSEL_W),
      .DEPTH (PIN_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr_addr),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // per-entry valid bits: an unwritten pin reads as function 0
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // capture valid and bypass a write landing on the same edge as the read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         vld_q_ff    <= valid_ff[rd_addr];
         fwd_ff      <= wr.en && (wr_addr == rd_addr);
         fwd_data_ff <= wr.data;
      end
   end

   always_comb begin
      if (fwd_ff) begin
         rd_data = fwd_data_ff;
      end else if (vld_q_ff) begin
         rd_data = ram_q;
      end else begin
         rd_data = '0;
      end
   end

endmodule

/* sv/gpc_exec.sv */
module gpc_exec #(
   parameter int PIN_COUNT = 54
) (
   input  gpc_pkg::req_word_type               item,
   input  logic                                enabled,
   input  logic [gpc_pkg::FSEL_W-1:0]          sel_rd,
   input  logic [gpc_pkg::LATCH_WIDTH-1:0]     latch,
   output gpc_pkg::rsp_word_type               result,
   output gpc_pkg::sel_wr_type                 sel_wr,
   output logic [gpc_pkg::LATCH_WIDTH-1:0]     latch_in
);

   import gpc_pkg::*;

   status_type             status;
   logic                   ok;
   logic [LATCH_WIDTH-1:0] pin_mask;
   logic [LATCH_WIDTH-1:0] pad_sh;

   // error priority: disabled, then unimplemented, then pin range
   always_comb begin
      if (!enabled) begin
         status = ST_DISABLED;
      end else if (item.cmd > CMD_WRITE_LEVEL) begin
         status = ST_UNIMPL;
      end else if ({1'b0, item.pin} >= (PIN_W + 1)'(PIN_COUNT)) begin
         status = ST_RANGE;
      end else begin
         status = ST_OK;
      end
   end

   assign ok       = (status == ST_OK);
   // shifts past the latch width give zero: pins 54 and up drive and read nothing
   assign pin_mask = LATCH_WIDTH'(1) << item.pin;
   assign pad_sh   = item.pad_levels >> item.pin;

   // command decode
   always_comb begin
      result.read_value    = '0;
      result.status        = status;
      result.pull_strobe   = 1'b0;
      result.pull_code     = '0;
      sel_wr.en            = 1'b0;
      sel_wr.addr          = item.pin;
      sel_wr.data          = item.value;
      latch_in             = latch;
      if (ok) begin
         case (cmd_type'(item.cmd))
            CMD_READ_MODE: begin
               result.read_value = sel_rd;
            end
            CMD_WRITE_MODE: begin
               sel_wr.en = 1'b1;
            end
            CMD_SET_PULL: begin
               result.pull_strobe = 1'b1;
               result.pull_code   = item.value[PULL_W-1:0];
            end
            CMD_READ_LEVEL: begin
               result.read_value = {{(FSEL_W-1){1'b0}}, pad_sh[0]};
            end
            CMD_WRITE_LEVEL: begin
               if (item.value != '0) begin
                  latch_in = latch | pin_mask;
               end else begin
                  latch_in = latch & ~pin_mask;
               end
            end
            default: begin
               latch_in = latch;
            end
         endcase
      end
      result.driven_levels = latch_in;
   end

endmodule

/* sv/gpio_pin_controller.sv */
// GPIO pin controller: function select, pull strobe and output latch for
// PIN_COUNT pins.
//
// Request stream (req_*): one command word per transfer, carrying the command,
// the pin number, a value and the sampled pad levels. Response stream (rsp_*):
// exactly one word per request, in order, with the read value, a status code,
// the output latch after the command and the pull strobe with its code.
// csr_wr_en / csr_wr_data write the enable bit; write it only while idle.
//
// Timing: an accepted request loads the input register; its response then
// moves to the response register, which drives rsp_tvalid, once that register
// is free. The block takes one word per cycle while rsp_tready keeps up; the
// input register and the function-select RAM read (registered, bypassing a
// write on the same edge) load on the same edge, then the response register.
//
// Reset clears the enable, the output latch and all function selects (the
// selects through per-pin valid bits, so no clearing pass is needed).
// When rsp_tready is low the response holds and one more request is taken
// into the input register; after that req_tready drops until space frees up.
module gpio_pin_controller #(
   parameter int PIN_COUNT = 54
) (
   input  logic                                clock,
   input  logic                                reset,
   // config
   input  logic                                csr_wr_en,
   input  logic                                csr_wr_data,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: cmd[2:0], pin[8:3], value[11:9], pad_levels[65:12], zero pad
   input  logic [gpc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: read_value[2:0], status[4:3], driven_levels[58:5],
   //        pull_strobe[59], pull_code[61:60], zero pad
   output logic [gpc_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   import gpc_pkg::*;

   logic                   enabled_ff;
   logic                   s1_valid_ff;
   req_word_type           s1_item_ff;
   logic                   rsp_valid_ff;
   rsp_word_type           rsp_word_ff;
   logic [LATCH_WIDTH-1:0] latch_ff;
   logic [LATCH_WIDTH-1:0] latch_in;

   logic                   req_accept;
   logic                   s1_adv;
   logic                   s1_fire;
   req_word_type           req_word;
   logic [FSEL_W-1:0]      sel_rd;
   sel_wr_type             exec_wr;
   sel_wr_type             sel_wr;
   rsp_word_type           result;

   assign req_word   = req_word_type'(req_tdata[REQ_USED_W-1:0]);
   assign s1_adv     = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && s1_adv;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_accept = req_tvalid && req_tready;

   // enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
      end else if (csr_wr_en) begin
         enabled_ff <= csr_wr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_word;
      end
   end

   // function select store, read as the word is accepted
   always_comb begin
      sel_wr    = exec_wr;
      sel_wr.en = exec_wr.en && s1_fire;
   end

   gpc_sel_store #(
      .PIN_COUNT (PIN_COUNT)
   ) u_sel (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_pin  (req_word.pin),
      .wr      (sel_wr),
      .rd_data (sel_rd)
   );

   gpc_exec #(
      .PIN_COUNT (PIN_COUNT)
   ) u_exec (
      .item     (s1_item_ff),
      .enabled  (enabled_ff),
      .sel_rd   (sel_rd),
      .latch    (latch_ff),
      .result   (result),
      .sel_wr   (exec_wr),
      .latch_in (latch_in)
   );

   // output latch commits as the command retires
   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff <= '0;
      end else if (s1_fire) begin
         latch_ff <= latch_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-RSP_USED_W){1'b0}}, rsp_word_ff};

endmodule

/* sv/gpc_checker.sv */
module gpc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [gpc_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [gpc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   import gpc_pkg::*;

   rsp_word_type rsp_word;

   assign rsp_word = rsp_word_type'(rsp_tdata[RSP_USED_W-1:0]);

   // a waiting request word holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("request word changed while waiting");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // nothing is left pending across reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a refused command reads nothing and strobes nothing
   a_err_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_word.status != ST_OK) |->
         (rsp_word.read_value == '0) && !rsp_word.pull_strobe &&
         (rsp_word.pull_code == '0))
      else $error("refused command produced data");

   // pull code only travels with the strobe
   a_pull_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_word.pull_strobe |-> rsp_word.pull_code == '0)
      else $error("pull code without strobe");

endmodule

bind gpio_pin_controller gpc_checker u_chk (.*);
